// ===== rtl/inode_block_map_walker_defines.svh =====
// ----------------------------------------------------------------------------
// Inode block map walker assertion macros
// Shared concurrent assertion forms for the walker RTL.
// ----------------------------------------------------------------------------
`ifndef INODE_BLOCK_MAP_WALKER_DEFINES_SVH
`define INODE_BLOCK_MAP_WALKER_DEFINES_SVH

// same-cycle implication
`define IBMW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IBMW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ibmw_pkg.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker package
// Shared types, codes and the level boundary table.
// ----------------------------------------------------------------------------
`default_nettype none

package ibmw_pkg;

   localparam int DIRECT_COUNT = 12;
   localparam int SLOT_COUNT   = 15;
   localparam int SLOT_W       = 4;
   localparam int WORD_W       = 32;
   localparam int LB_W         = 44;
   localparam int IDX_W        = 14;
   localparam int OFS_W        = 28;
   localparam int LVL_W        = 2;
   localparam int EXP_W        = 3;
   localparam int SH_W         = 5;

   localparam logic [SLOT_W-1:0] SLOT_SINGLE = 4'd12;
   localparam logic [SLOT_W-1:0] SLOT_DOUBLE = 4'd13;
   localparam logic [SLOT_W-1:0] SLOT_TRIPLE = 4'd14;
   localparam logic [EXP_W-1:0]  MAX_EXP     = 3'd6;

   typedef enum logic [1:0] {
      ACT_LOAD      = 2'd0,
      ACT_TRANSLATE = 2'd1,
      ACT_RESPONSE  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_REQ  = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_BLOCK_SIZE_EXP = 1'b0,
      CSR_BLOCK_LIMIT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [EXP_W-1:0]  block_size_exp;
      logic [WORD_W-1:0] block_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] word;
      logic [LB_W-1:0]   file_block;
   } item_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [WORD_W-1:0] ptr_block;
      logic [IDX_W-1:0]  entry_index;
      logic [WORD_W-1:0] phys_block;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [WORD_W-1:0] data;
   } slot_wr_type;

   typedef struct packed {
      logic [WORD_W-1:0] direct;
      logic [WORD_W-1:0] ptr_single;
      logic [WORD_W-1:0] ptr_dbl;
      logic [WORD_W-1:0] ptr_tri;
   } slot_view_type;

   typedef struct packed {
      logic [LB_W-1:0] single_end;
      logic [LB_W-1:0] double_end;
      logic [LB_W-1:0] triple_end;
   } bounds_type;

   // first logical block past each indirect range for a given exponent
   function automatic bounds_type level_bounds(input logic [EXP_W-1:0] e);
      bounds_type      b;
      logic [LB_W-1:0] span1;
      logic [LB_W-1:0] span2;
      logic [LB_W-1:0] span3;
      span1 = LB_W'(1) << (8 + 32'(e));
      span2 = LB_W'(1) << (16 + 2 * 32'(e));
      span3 = LB_W'(1) << (24 + 3 * 32'(e));
      b.single_end = LB_W'(DIRECT_COUNT) + span1;
      b.double_end = b.single_end + span2;
      b.triple_end = b.double_end + span3;
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/inode_block_map_walker.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker
// Maps logical file blocks to physical blocks through an inode's direct and
// indirect block pointers.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while the result side does not stall.
// A result, if any, is decoded from the input register by the single decode
// stage and registered in the result register; a stalled result holds the
// input register and so the input. A translation of a block in an indirect
// range issues one read request result per pointer level (up to three);
// each memory word must be returned as a response transaction, and the walk
// ignores loads and translations until it ends with a done or error result.
// Physical block 0 on a done result marks a hole.
`default_nettype none

module inode_block_map_walker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [ibmw_pkg::SLOT_W-1:0]  req_slot,
   input  logic [ibmw_pkg::WORD_W-1:0]  req_word,
   input  logic [ibmw_pkg::LB_W-1:0]    req_file_block,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [ibmw_pkg::WORD_W-1:0]  rsp_ptr_block,
   output logic [ibmw_pkg::IDX_W-1:0]   rsp_entry_index,
   output logic [ibmw_pkg::WORD_W-1:0]  rsp_phys_block,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [ibmw_pkg::WORD_W-1:0]  csr_data
);
   import ibmw_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   item_type      item_ff;
   logic          accept;
   logic          adv;
   logic          fire;
   cfg_type       cfg;
   slot_view_type view;
   slot_wr_type   slot_wr;
   result_type    res;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   result_type    rsp_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && adv;
   assign req_stall = in_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !adv);
   assign rsp_valid_in = adv ? (fire && res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action     <= req_action;
         item_ff.slot       <= req_slot;
         item_ff.word       <= req_word;
         item_ff.file_block <= req_file_block;
      end
      if (fire && res.valid) begin
         rsp_ff <= res;
      end
   end

   ibmw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ibmw_slots u_slots (
      .clock  (clock),
      .reset  (reset),
      .wr     (slot_wr),
      .rd_idx (item_ff.file_block[SLOT_W-1:0]),
      .view   (view)
   );

   ibmw_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .cfg     (cfg),
      .view    (view),
      .slot_wr (slot_wr),
      .res     (res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_ptr_block   = rsp_ff.ptr_block;
   assign rsp_entry_index = rsp_ff.entry_index;
   assign rsp_phys_block  = rsp_ff.phys_block;

endmodule

`default_nettype wire

// ===== rtl/ibmw_csr.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker configuration registers
// Block size exponent and volume block limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmw_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [ibmw_pkg::WORD_W-1:0] csr_data,
   output ibmw_pkg::cfg_type          cfg
);
   import ibmw_pkg::*;

   logic [EXP_W-1:0]  exp_ff;
   logic [EXP_W-1:0]  exp_in;
   logic [WORD_W-1:0] limit_ff;
   logic [WORD_W-1:0] limit_in;
   logic              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      exp_in   = exp_ff;
      limit_in = limit_ff;
      if (wr) begin
         case (csr_index)
            CSR_BLOCK_SIZE_EXP: exp_in   = csr_data[EXP_W-1:0];
            CSR_BLOCK_LIMIT:    limit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff   <= '0;
         limit_ff <= WORD_W'(1);
      end else begin
         exp_ff   <= exp_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.block_size_exp = exp_ff;
   assign cfg.block_limit    = limit_ff;

endmodule

`default_nettype wire

// ===== rtl/ibmw_slots.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker pointer slots
// The inode's fifteen block pointers: twelve direct, then single, double and
// triple indirect.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmw_slots (
   input  logic                        clock,
   input  logic                        reset,
   input  ibmw_pkg::slot_wr_type       wr,
   input  logic [ibmw_pkg::SLOT_W-1:0] rd_idx,
   output ibmw_pkg::slot_view_type     view
);
   import ibmw_pkg::*;

   logic [WORD_W-1:0] slots_ff [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (wr.en) begin
         slots_ff[wr.idx] <= wr.data;
      end
   end

   assign view.direct     = slots_ff[rd_idx];
   assign view.ptr_single = slots_ff[SLOT_SINGLE];
   assign view.ptr_dbl    = slots_ff[SLOT_DOUBLE];
   assign view.ptr_tri    = slots_ff[SLOT_TRIPLE];

endmodule

`default_nettype wire

// ===== rtl/ibmw_walk.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker translation logic
// Decodes one transaction against the walk state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inode_block_map_walker_defines.svh"

module ibmw_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ibmw_pkg::item_type      item,
   input  ibmw_pkg::cfg_type       cfg,
   input  ibmw_pkg::slot_view_type view,
   output ibmw_pkg::slot_wr_type   slot_wr,
   output ibmw_pkg::result_type    res
);
   import ibmw_pkg::*;

   logic              busy_ff;
   logic              busy_in;
   logic [LVL_W-1:0]  levels_ff;
   logic [LVL_W-1:0]  levels_in;
   logic [OFS_W-1:0]  rem_ff;
   logic [OFS_W-1:0]  rem_in;

   logic [EXP_W-1:0]  eff;
   logic [SH_W-1:0]   sh1;
   logic [SH_W-1:0]   sh2;
   logic [OFS_W-1:0]  per_mask;
   logic [OFS_W-1:0]  dbl_mask;
   bounds_type        bounds;
   logic [LB_W-1:0]   off1;
   logic [LB_W-1:0]   off2;
   logic [LB_W-1:0]   off3;
   logic              issue;
   logic [WORD_W-1:0] issue_ptr;
   logic [IDX_W-1:0]  issue_idx;

   always_comb begin
      eff      = (cfg.block_size_exp > MAX_EXP) ? MAX_EXP : cfg.block_size_exp;
      sh1      = SH_W'(8) + SH_W'(eff);
      sh2      = SH_W'(16) + {1'b0, eff, 1'b0};
      per_mask = (OFS_W'(1) << sh1) - OFS_W'(1);
      dbl_mask = (OFS_W'(1) << sh2) - OFS_W'(1);
      bounds   = level_bounds(eff);
      off1     = item.file_block - LB_W'(DIRECT_COUNT);
      off2     = item.file_block - bounds.single_end;
      off3     = item.file_block - bounds.double_end;

      busy_in   = busy_ff;
      levels_in = levels_ff;
      rem_in    = rem_ff;
      slot_wr   = '0;
      res       = '0;
      issue     = 1'b0;
      issue_ptr = '0;
      issue_idx = '0;

      case (item.action)
         ACT_LOAD: begin
            if (fire && !busy_ff && (item.slot < SLOT_W'(SLOT_COUNT))) begin
               slot_wr.en   = 1'b1;
               slot_wr.idx  = item.slot;
               slot_wr.data = item.word;
            end
         end
         ACT_TRANSLATE: begin
            if (fire && !busy_ff) begin
               if (item.file_block < LB_W'(DIRECT_COUNT)) begin
                  res.valid = 1'b1;
                  if (view.direct >= cfg.block_limit) begin
                     res.kind = KIND_ERR;
                  end else begin
                     res.kind       = KIND_DONE;
                     res.phys_block = view.direct;
                  end
               end else if (item.file_block < bounds.single_end) begin
                  levels_in = '0;
                  rem_in    = '0;
                  issue     = 1'b1;
                  issue_ptr = view.ptr_single;
                  issue_idx = off1[IDX_W-1:0];
               end else if (item.file_block < bounds.double_end) begin
                  levels_in = LVL_W'(1);
                  rem_in    = off2[OFS_W-1:0] & per_mask;
                  issue     = 1'b1;
                  issue_ptr = view.ptr_dbl;
                  issue_idx = IDX_W'(off2[OFS_W-1:0] >> sh1);
               end else if (item.file_block < bounds.triple_end) begin
                  levels_in = LVL_W'(2);
                  rem_in    = off3[OFS_W-1:0] & dbl_mask;
                  issue     = 1'b1;
                  issue_ptr = view.ptr_tri;
                  issue_idx = IDX_W'(off3[LB_W-3:0] >> sh2);
               end else begin
                  res.valid = 1'b1;
                  res.kind  = KIND_ERR;
               end
            end
         end
         ACT_RESPONSE: begin
            if (fire && busy_ff) begin
               if (item.word >= cfg.block_limit) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_ERR;
                  busy_in   = 1'b0;
                  levels_in = '0;
                  rem_in    = '0;
               end else if (levels_ff == '0) begin
                  res.valid      = 1'b1;
                  res.kind       = KIND_DONE;
                  res.phys_block = item.word;
                  busy_in        = 1'b0;
                  rem_in         = '0;
               end else if (levels_ff >= LVL_W'(2)) begin
                  levels_in = LVL_W'(1);
                  rem_in    = rem_ff & per_mask;
                  issue     = 1'b1;
                  issue_ptr = item.word;
                  issue_idx = IDX_W'(rem_ff >> sh1);
               end else begin
                  levels_in = '0;
                  rem_in    = '0;
                  issue     = 1'b1;
                  issue_ptr = item.word;
                  issue_idx = rem_ff[IDX_W-1:0];
               end
            end
         end
         default: ;
      endcase

      // pointer read: a zero pointer is a hole, an out-of-range one an error
      if (issue) begin
         res.valid = 1'b1;
         if (issue_ptr == '0) begin
            res.kind  = KIND_DONE;
            busy_in   = 1'b0;
            levels_in = '0;
            rem_in    = '0;
         end else if (issue_ptr >= cfg.block_limit) begin
            res.kind  = KIND_ERR;
            busy_in   = 1'b0;
            levels_in = '0;
            rem_in    = '0;
         end else begin
            res.kind        = KIND_REQ;
            res.ptr_block   = issue_ptr;
            res.entry_index = issue_idx;
            busy_in         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         levels_ff <= '0;
         rem_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         levels_ff <= levels_in;
         rem_ff    <= rem_in;
      end
   end

   `IBMW_ASSERT_NXT(a_req_leaves_busy, clock, reset,
      res.valid && (res.kind == KIND_REQ), busy_ff, "read request without busy walk")
   `IBMW_ASSERT_NXT(a_end_leaves_idle, clock, reset,
      res.valid && ((res.kind == KIND_DONE) || (res.kind == KIND_ERR)), !busy_ff,
      "walk still busy after final result")
   `IBMW_ASSERT_IMP(a_last_level_no_rem, clock, reset,
      busy_ff && (levels_ff == '0), rem_ff == '0, "offset left on last level")
   `IBMW_ASSERT_IMP(a_no_load_in_walk, clock, reset,
      slot_wr.en, !busy_ff && !res.valid, "slot load during walk")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Inode block map walker testbench
// Loads pointer slots, translates logical blocks and answers every pointer
// read with a memory word transaction. A scoreboard predicts each result
// from its own copy of the slots, registers and walk state, and checks the
// result stream in order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

import ibmw_pkg::*;

typedef struct {
   kind_type          kind;
   logic [WORD_W-1:0] ptr_block;
   logic [IDX_W-1:0]  entry_index;
   logic [WORD_W-1:0] phys_block;
} map_result_type;

class map_scoreboard_type;
   logic [EXP_W-1:0]  size_exp;
   logic [WORD_W-1:0] vol_blocks;
   logic [WORD_W-1:0] ptr_table [SLOT_COUNT];
   bit                walk_open;
   int unsigned       depth_to_go;
   logic [63:0]       subtree_ofs;
   map_result_type    due_results [$];
   int unsigned       bad_count;
   int unsigned       seen_req;
   int unsigned       seen_done;
   int unsigned       seen_hole;
   int unsigned       seen_err;

   function new();
      size_exp    = '0;
      vol_blocks  = 32'd1;
      foreach (ptr_table[i]) ptr_table[i] = '0;
      walk_open   = 1'b0;
      depth_to_go = 0;
      subtree_ofs = '0;
      bad_count   = 0;
      seen_req    = 0;
      seen_done   = 0;
      seen_hole   = 0;
      seen_err    = 0;
   endfunction

   function void set_register(csr_index_type idx, logic [WORD_W-1:0] data);
      if (idx == CSR_BLOCK_SIZE_EXP) begin
         size_exp = data[EXP_W-1:0];
      end else begin
         vol_blocks = data;
      end
   endfunction

   function int unsigned pending();
      return due_results.size();
   endfunction

   function void push_result(kind_type k, logic [WORD_W-1:0] pb, logic [63:0] ei,
                             logic [WORD_W-1:0] pv);
      map_result_type r;
      r.kind        = k;
      r.ptr_block   = pb;
      r.entry_index = ei[IDX_W-1:0];
      r.phys_block  = pv;
      due_results.push_back(r);
   endfunction

   function void close_walk();
      walk_open   = 1'b0;
      depth_to_go = 0;
      subtree_ofs = '0;
   endfunction

   // zero pointer is a hole, out-of-volume pointer aborts the walk
   function void start_read(logic [WORD_W-1:0] ptr, logic [63:0] ei);
      if (ptr == '0) begin
         close_walk();
         push_result(KIND_DONE, '0, '0, '0);
      end else if (ptr >= vol_blocks) begin
         close_walk();
         push_result(KIND_ERR, '0, '0, '0);
      end else begin
         walk_open = 1'b1;
         push_result(KIND_REQ, ptr, ei, '0);
      end
   endfunction

   function void take_item(logic [1:0] act, logic [SLOT_W-1:0] slot,
                           logic [WORD_W-1:0] word, logic [LB_W-1:0] lb);
      logic [EXP_W-1:0] e;
      int unsigned      sh1;
      int unsigned      sh2;
      logic [63:0]      per;
      logic [63:0]      dbl;
      logic [63:0]      trp;
      logic [63:0]      ofs;
      logic [63:0]      idx;
      e   = (size_exp > MAX_EXP) ? MAX_EXP : size_exp;
      sh1 = 8 + e;
      sh2 = 16 + 2 * e;
      per = 64'd1 << sh1;
      dbl = 64'd1 << sh2;
      trp = 64'd1 << (24 + 3 * e);
      ofs = 64'(lb);
      case (act)
         ACT_LOAD: begin
            if (!walk_open && slot < SLOT_COUNT) ptr_table[slot] = word;
         end
         ACT_TRANSLATE: begin
            if (!walk_open) begin
               if (ofs < DIRECT_COUNT) begin
                  if (ptr_table[ofs[3:0]] >= vol_blocks) begin
                     push_result(KIND_ERR, '0, '0, '0);
                  end else begin
                     push_result(KIND_DONE, '0, '0, ptr_table[ofs[3:0]]);
                  end
               end else begin
                  ofs = ofs - DIRECT_COUNT;
                  if (ofs < per) begin
                     depth_to_go = 0;
                     subtree_ofs = '0;
                     start_read(ptr_table[SLOT_SINGLE], ofs);
                  end else begin
                     ofs = ofs - per;
                     if (ofs < dbl) begin
                        depth_to_go = 1;
                        subtree_ofs = ofs & (per - 1);
                        start_read(ptr_table[SLOT_DOUBLE], ofs >> sh1);
                     end else begin
                        ofs = ofs - dbl;
                        if (ofs >= trp) begin
                           push_result(KIND_ERR, '0, '0, '0);
                        end else begin
                           depth_to_go = 2;
                           subtree_ofs = ofs & (dbl - 1);
                           start_read(ptr_table[SLOT_TRIPLE], ofs >> sh2);
                        end
                     end
                  end
               end
            end
         end
         ACT_RESPONSE: begin
            if (walk_open) begin
               if (word >= vol_blocks) begin
                  close_walk();
                  push_result(KIND_ERR, '0, '0, '0);
               end else if (depth_to_go == 0) begin
                  close_walk();
                  push_result(KIND_DONE, '0, '0, word);
               end else if (depth_to_go >= 2) begin
                  idx         = subtree_ofs >> sh1;
                  subtree_ofs = subtree_ofs & (per - 1);
                  depth_to_go = 1;
                  start_read(word, idx);
               end else begin
                  idx         = subtree_ofs;
                  subtree_ofs = '0;
                  depth_to_go = 0;
                  start_read(word, idx);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void check_result(logic [1:0] kind, logic [WORD_W-1:0] pb,
                              logic [IDX_W-1:0] ei, logic [WORD_W-1:0] pv);
      map_result_type want;
      if (due_results.size() == 0) begin
         bad_count++;
         if (bad_count <= 10)
            $display("unexpected result: kind=%0d block=%0d index=%0d phys=%0d",
                     kind, pb, ei, pv);
         return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind || pb !== want.ptr_block ||
          ei !== want.entry_index || pv !== want.phys_block) begin
         bad_count++;
         if (bad_count <= 10) begin
            $display("mismatch: exp kind=%0d block=%0d index=%0d phys=%0d",
                     want.kind, want.ptr_block, want.entry_index, want.phys_block);
            $display("          got kind=%0d block=%0d index=%0d phys=%0d",
                     kind, pb, ei, pv);
         end
      end else begin
         case (want.kind)
            KIND_REQ:  seen_req++;
            KIND_DONE: begin
               seen_done++;
               if (pv == '0) seen_hole++;
            end
            default:   seen_err++;
         endcase
      end
   endfunction
endclass

module tb_top;

   localparam logic [1:0]        ACT_UNUSED  = 2'd3;
   localparam logic [SLOT_W-1:0] SLOT_NONE   = 4'd15;
   localparam int unsigned       QUIET_LIMIT = 5000;
   localparam int unsigned       PHASES      = 10;
   localparam int unsigned       PHASE_ITEMS = 170;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic [1:0]          req_action        = '0;
   logic [SLOT_W-1:0]   req_slot          = '0;
   logic [WORD_W-1:0]   req_word          = '0;
   logic [LB_W-1:0]     req_file_block    = '0;
   logic                rsp_stall         = 1'b0;
   logic                csr_valid         = 1'b0;
   logic                csr_index         = 1'b0;
   logic [WORD_W-1:0]   csr_data          = '0;
   wire logic           req_stall;
   wire logic           rsp_valid;
   wire logic [1:0]     rsp_kind;
   wire logic [WORD_W-1:0] rsp_ptr_block;
   wire logic [IDX_W-1:0]  rsp_entry_index;
   wire logic [WORD_W-1:0] rsp_phys_block;
   wire logic           csr_ready;

   map_scoreboard_type sb = new();

   int unsigned sent_count  = 0;
   int unsigned quiet       = 0;
   int unsigned stall_left  = 0;
   bit          rsp_took    = 1'b0;
   bit          rsp_calm    = 1'b0;
   bit          send_calm   = 1'b0;

   inode_block_map_walker u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_slot        (req_slot),
      .req_word        (req_word),
      .req_file_block  (req_file_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_ptr_block   (rsp_ptr_block),
      .rsp_entry_index (rsp_entry_index),
      .rsp_phys_block  (rsp_phys_block),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // result side: stall for a random count after every accepted transaction
   always @(negedge clock) begin
      if (rsp_took) begin
         stall_left = rsp_calm ? 0 : $urandom_range(10, 0);
         if ($urandom_range(29, 0) == 0) rsp_calm = !rsp_calm;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_took = 1'b0;
         quiet    = 0;
      end else begin
         rsp_took = rsp_valid && !rsp_stall;
         if (rsp_took)
            sb.check_result(rsp_kind, rsp_ptr_block, rsp_entry_index, rsp_phys_block);
         if (rsp_took || (req_valid && !req_stall) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mostly valid pointers, some holes, some outside the volume
   function automatic logic [WORD_W-1:0] pick_pointer();
      int unsigned       r;
      logic [WORD_W-1:0] lim;
      r   = $urandom_range(9, 0);
      lim = sb.vol_blocks;
      if (r == 0) return '0;
      if (r == 1) return (lim == '1) ? '1 : $urandom_range(32'hFFFF_FFFF, lim);
      if (r == 2 || lim <= 1) return $urandom();
      return $urandom_range(lim - 1, 1);
   endfunction

   function automatic logic [LB_W-1:0] pick_block();
      logic [EXP_W-1:0] e;
      logic [63:0]      per;
      logic [63:0]      dbl;
      logic [63:0]      trp;
      logic [63:0]      base;
      logic [63:0]      span;
      logic [63:0]      ofs;
      int unsigned      r;
      int unsigned      corner;
      e   = (sb.size_exp > MAX_EXP) ? MAX_EXP : sb.size_exp;
      per = 64'd1 << (8 + e);
      dbl = 64'd1 << (16 + 2 * e);
      trp = 64'd1 << (24 + 3 * e);
      r   = $urandom_range(99, 0);
      if (r < 15) return LB_W'($urandom_range(DIRECT_COUNT - 1, 0));
      if (r < 40) begin
         base = DIRECT_COUNT;
         span = per;
      end else if (r < 65) begin
         base = DIRECT_COUNT + per;
         span = dbl;
      end else if (r < 90) begin
         base = DIRECT_COUNT + per + dbl;
         span = trp;
      end else begin
         base = DIRECT_COUNT + per + dbl + trp;
         span = (64'd1 << LB_W) - base;
      end
      corner = $urandom_range(7, 0);
      if (corner == 0) begin
         ofs = '0;
      end else if (corner == 1) begin
         ofs = span - 1;
      end else begin
         ofs = rand64() % span;
      end
      return LB_W'(base + ofs);
   endfunction

   task automatic send_item(logic [1:0] act, logic [SLOT_W-1:0] slot,
                            logic [WORD_W-1:0] word, logic [LB_W-1:0] lb);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(10, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_slot       <= slot;
      req_word       <= word;
      req_file_block <= lb;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_item(act, slot, word, lb);
      sent_count++;
      if ($urandom_range(39, 0) == 0) send_calm = !send_calm;
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [WORD_W-1:0] data);
      wait_results();
      // let a trailing transaction with no result clear the pipeline
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic finish_walk();
      while (sb.walk_open)
         send_item(ACT_RESPONSE, SLOT_W'($urandom_range(15, 0)), pick_pointer(),
                   LB_W'(rand64()));
   endtask

   task automatic run_random(int unsigned count);
      int unsigned n;
      int unsigned r;
      n = 0;
      while (n < count) begin
         r = $urandom_range(99, 0);
         if (sb.walk_open) begin
            if (r < 85) begin
               send_item(ACT_RESPONSE, SLOT_W'($urandom_range(15, 0)), pick_pointer(),
                         LB_W'(rand64()));
               n++;
            end else if (r < 90) begin
               send_item(ACT_LOAD, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         LB_W'(rand64()));
            end else if (r < 95) begin
               send_item(ACT_TRANSLATE, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         pick_block());
            end else begin
               send_item(ACT_UNUSED, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         LB_W'(rand64()));
            end
         end else begin
            if (r < 25) begin
               send_item(ACT_LOAD, SLOT_W'($urandom_range(15, 0)), pick_pointer(),
                         LB_W'(rand64()));
               n++;
            end else if (r < 85) begin
               send_item(ACT_TRANSLATE, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         pick_block());
               n++;
            end else if (r < 92) begin
               send_item(ACT_RESPONSE, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         LB_W'(rand64()));
            end else begin
               send_item(ACT_UNUSED, SLOT_W'($urandom_range(15, 0)), $urandom(),
                         LB_W'(rand64()));
            end
            if ($urandom_range(59, 0) == 0) wait_results();
         end
      end
      finish_walk();
   endtask

   initial begin
      logic [EXP_W-1:0]  e;
      logic [WORD_W-1:0] lim;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 256 entries per pointer block, 100000 blocks
      write_register(CSR_BLOCK_SIZE_EXP, 32'd0);
      write_register(CSR_BLOCK_LIMIT, 32'd100000);
      send_item(ACT_LOAD, 4'd0, 32'd500, '0);
      send_item(ACT_LOAD, 4'd11, 32'd100000, '0);
      send_item(ACT_LOAD, SLOT_SINGLE, 32'd700, '0);
      send_item(ACT_LOAD, SLOT_DOUBLE, 32'd800, '0);
      send_item(ACT_LOAD, SLOT_TRIPLE, 32'd900, '0);
      send_item(ACT_LOAD, SLOT_NONE, '1, '1);
      send_item(ACT_UNUSED, '1, '1, '1);
      send_item(ACT_TRANSLATE, '0, '0, 44'd0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd11);
      send_item(ACT_TRANSLATE, '0, '0, 44'd5);
      send_item(ACT_RESPONSE, '0, 32'd77, '0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd12);
      send_item(ACT_TRANSLATE, '0, '0, 44'd20);
      send_item(ACT_LOAD, 4'd0, 32'd9, '0);
      send_item(ACT_RESPONSE, '0, 32'd1234, '0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd65803);
      send_item(ACT_RESPONSE, '0, 32'd0, '0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd65804);
      send_item(ACT_RESPONSE, '0, 32'd4000, '0);
      send_item(ACT_RESPONSE, '0, 32'd4001, '0);
      send_item(ACT_RESPONSE, '0, 32'd99999, '0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd16843019);
      send_item(ACT_RESPONSE, '0, 32'd100000, '0);
      send_item(ACT_TRANSLATE, '0, '0, 44'd16843020);
      send_item(ACT_TRANSLATE, '1, '1, '1);
      finish_walk();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin e = 3'd0; lim = 32'd100000;   end
            1:       begin e = 3'd6; lim = 32'hFFFF_FFFF; end
            2:       begin e = 3'd7; lim = $urandom_range(32'hFFFF_FFFF, 1); end
            3:       begin e = 3'd3; lim = 32'd1;        end
            4:       begin e = 3'd1; lim = 32'd5000;     end
            5:       begin e = 3'd6; lim = $urandom_range(32'hFFFF_FFFF, 1); end
            6:       begin e = 3'd2; lim = 32'hFFFF_FFFF; end
            7:       begin e = 3'd0; lim = 32'd2;        end
            8:       begin e = 3'd5; lim = $urandom_range(32'hFFFF_FFFF, 1); end
            default: begin e = 3'd4; lim = 32'd200;      end
         endcase
         write_register(CSR_BLOCK_SIZE_EXP, 32'(e));
         write_register(CSR_BLOCK_LIMIT, lim);
         run_random(PHASE_ITEMS);
      end

      wait_results();
      repeat (10) @(posedge clock);
      $display("run: %0d transactions over %0d register settings, exponents 0 to 7",
               sent_count, PHASES + 1);
      $display("results: %0d reads, %0d done (%0d holes), %0d errors, %0d bad",
               sb.seen_req, sb.seen_done, sb.seen_hole, sb.seen_err, sb.bad_count);
      if (sb.bad_count == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ibmw_pkg.sv
rtl/ibmw_csr.sv
rtl/ibmw_slots.sv
rtl/ibmw_walk.sv
rtl/inode_block_map_walker.sv
sim/tb_top.sv
